// ===== sv/bloom_filter_insert_query_defines.svh =====
// assertion macros for the bloom filter block
`ifndef BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH
`define BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH

// assert that a condition implies a consequence in the same cycle
`define BFIQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// assert that a condition implies a consequence in the next cycle
`define BFIQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bfiq_pkg.sv =====
// package with types, constants and hash helpers for the bloom filter block
package bfiq_pkg;

    localparam int MAX_BITS = 65536;
    localparam int MAX_HASHES = 32;
    localparam int IDX_W = $clog2(MAX_BITS);
    localparam int CNT_W = $clog2(MAX_BITS + 1);
    localparam int PRB_W = $clog2(MAX_HASHES + 1);
    localparam int BITCNT_W = 17;
    localparam int HASHCNT_W = 6;

    localparam logic [63:0] MIX_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;

    // register indexes of the configuration port
    localparam logic [0:0] REG_BIT_COUNT = 1'b0;
    localparam logic [0:0] REG_HASH_COUNT = 1'b1;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // multiplier operand selects
    typedef enum logic [2:0] {
        MS_C1,
        MS_C2,
        MS_FM1,
        MS_FM2,
        MS_FIVE
    } mul_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AB_K1A,
        ST_AB_K1B,
        ST_AB_H1,
        ST_AB_K2A,
        ST_AB_K2B,
        ST_AB_H2,
        ST_FN_T2A,
        ST_FN_T2B,
        ST_FN_T1A,
        ST_FN_T1B,
        ST_FN_MIX,
        ST_FM_H1A,
        ST_FM_H1B,
        ST_FM_H2A,
        ST_FM_H2B,
        ST_FN_END,
        ST_PR_MOD,
        ST_PR_MEM,
        ST_PR_CHK,
        ST_RESULT,
        ST_CLEAR
    } state_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        rotl64 = (x << r) | (x >> (64 - r));
    endfunction

    // little endian load of the first n bytes of a 64-bit lane
    function automatic logic [63:0] load_bytes(input logic [63:0] lane, input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < n)
            begin
                m[8*i +: 8] = 8'hff;
            end
        end
        load_bytes = lane & m;
    endfunction

endpackage

// ===== sv/bloom_filter_insert_query.sv =====
// Bloom filter with insert and query, keyed by MurmurHash3 x64 128 with seed 0.
// After reset a clearing pass over all MAX_BITS (65536) bits zeroes the bit store,
// and no word is taken until it ends. A key arrives one byte word per beat. A word
// that does not complete a 16-byte block and is not last is only stored. A word that
// completes a block runs the block absorb: six 64-bit products, each built in three
// passes through one shared 32x32 multiplier. A last word runs the tail and
// finalization hashing (after the absorb if it also completes a block), then per
// probe a restoring divider for the modulo by bit_count, one memory read, one check
// and write, then one result step; the input is ready again only after that. A query
// stops at the first clear bit. A result stalled on the output holds the sequencer
// in its result step.
`include "bloom_filter_insert_query_defines.svh"
module bloom_filter_insert_query
    import bfiq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // key_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // req_type[0], has_byte[1]
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // req_type[0], possibly_present[1], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    state_t state_reg, state_next;

    logic [BITCNT_W-1:0]  bit_count_reg;
    logic [HASHCNT_W-1:0] hash_count_reg;

    logic [127:0] blk_reg, blk_next;
    logic [31:0]  len_reg, len_next;
    logic [63:0]  h1_reg, h1_next, h2_reg, h2_next;
    logic [63:0]  t_reg, t_next;
    logic         qry_reg, qry_next;
    logic         present_reg, present_next;
    logic [PRB_W-1:0] probe_reg, probe_next;
    logic [PRB_W-1:0] probes_lim;
    logic [63:0]  pos_reg, pos_next;     // a + k*b
    logic [CNT_W-1:0] size_val;

    // shared multiplier, low 64 bits of a 64x64 product in three passes
    mul_sel_t    msel;
    logic [63:0] mul_a, mul_b, mul_p;
    logic [1:0]  mstep_reg, mstep_next;
    logic [63:0] macc_reg, macc_next;
    logic        mul_use;
    logic        mul_done;
    logic [31:0] mop_x, mop_y;
    logic [63:0] mpp;

    // divider for the modulo
    logic [63:0]  div_q_reg, div_q_next;
    logic [CNT_W-1:0] div_r_reg, div_r_next;
    logic [6:0]   div_cnt_reg, div_cnt_next;
    logic [CNT_W:0] div_trial;

    // bit memory
    logic         mem [MAX_BITS];
    logic         mem_rd_reg;
    logic [IDX_W-1:0] mem_addr;
    logic         mem_we;
    logic         mem_wd;
    logic [IDX_W:0] clr_reg, clr_next;

    logic         out_valid_reg, out_valid_next;
    logic [1:0]   out_data_reg, out_data_next;

    logic in_acc;
    logic [3:0] pos4;
    logic [3:0] rem4;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {6'd0, out_data_reg};
    assign pos4 = len_reg[3:0];
    assign rem4 = len_reg[3:0];

    // effective size and probe count
    always_comb
    begin
        if (bit_count_reg == '0)
        begin
            size_val = CNT_W'(1);
        end
        else if (32'(bit_count_reg) > 32'(MAX_BITS))
        begin
            size_val = CNT_W'(MAX_BITS);
        end
        else
        begin
            size_val = CNT_W'(bit_count_reg);
        end
        if (32'(hash_count_reg) > 32'(MAX_HASHES))
        begin
            probes_lim = PRB_W'(MAX_HASHES);
        end
        else
        begin
            probes_lim = PRB_W'(hash_count_reg);
        end
    end

    // shared multiplier: lo*lo, then lo*hi, then hi*lo into the upper half
    always_comb
    begin
        unique case (msel)
            MS_C1:   mul_b = MIX_C1;
            MS_C2:   mul_b = MIX_C2;
            MS_FM1:  mul_b = FMIX_C1;
            MS_FM2:  mul_b = FMIX_C2;
            MS_FIVE: mul_b = 64'd5;
            default: mul_b = 64'd0;
        endcase
        mop_x = (mstep_reg == 2'd2) ? mul_a[63:32] : mul_a[31:0];
        mop_y = (mstep_reg == 2'd1) ? mul_b[63:32] : mul_b[31:0];
        mpp = {32'd0, mop_x} * {32'd0, mop_y};
        if (mstep_reg == 2'd0)
        begin
            mul_p = mpp;
        end
        else
        begin
            mul_p = macc_reg + {mpp[31:0], 32'd0};
        end
    end

    assign mul_done = (mstep_reg == 2'd2);
    assign macc_next = mul_p;

    assign div_trial = {div_r_reg, div_q_reg[63]} - {1'b0, size_val};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= 17'd65536;
            hash_count_reg <= 6'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BIT_COUNT:  bit_count_reg <= cfg_data;
                REG_HASH_COUNT: hash_count_reg <= cfg_data[HASHCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            clr_reg <= '0;
            blk_reg <= '0;
            len_reg <= '0;
            h1_reg <= '0;
            h2_reg <= '0;
            mstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            clr_reg <= clr_next;
            blk_reg <= blk_next;
            len_reg <= len_next;
            h1_reg <= h1_next;
            h2_reg <= h2_next;
            mstep_reg <= mstep_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        qry_reg <= qry_next;
        present_reg <= present_next;
        probe_reg <= probe_next;
        pos_reg <= pos_next;
        div_q_reg <= div_q_next;
        div_r_reg <= div_r_next;
        div_cnt_reg <= div_cnt_next;
        out_data_reg <= out_data_next;
        macc_reg <= macc_next;
    end

    // bit memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wd;
        end
        mem_rd_reg <= mem[mem_addr];
    end

    // sequencer
    always_comb
    begin
        logic [63:0] x;
        state_next = state_reg;
        blk_next = blk_reg;
        len_next = len_reg;
        h1_next = h1_reg;
        h2_next = h2_reg;
        t_next = t_reg;
        qry_next = qry_reg;
        present_next = present_reg;
        probe_next = probe_reg;
        pos_next = pos_reg;
        div_q_next = div_q_reg;
        div_r_next = div_r_reg;
        div_cnt_next = div_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        clr_next = clr_reg;
        msel = MS_C1;
        mul_a = t_reg;
        mul_use = 1'b0;
        mstep_next = '0;
        mem_addr = div_r_reg[IDX_W-1:0];
        mem_we = 1'b0;
        mem_wd = 1'b1;
        x = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_addr = clr_reg[IDX_W-1:0];
                mem_we = 1'b1;
                mem_wd = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (IDX_W+1)'(MAX_BITS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    qry_next = s_axis_tuser[0];
                    if (s_axis_tuser[1])
                    begin
                        blk_next[8*pos4 +: 8] = s_axis_tdata;
                        len_next = len_reg + 32'd1;
                    end
                    if (s_axis_tuser[1] && pos4 == 4'd15)
                    begin
                        t_next = blk_reg[63:0];
                        state_next = ST_AB_K1A;
                        present_next = s_axis_tlast;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_FN_T2A;
                        if (s_axis_tuser[1])
                        begin
                            t_next = load_bytes(blk_next[127:64], 4'(rem4 + 4'd1) - 4'd8);
                        end
                        else
                        begin
                            t_next = load_bytes(blk_reg[127:64], rem4 - 4'd8);
                        end
                    end
                end
            end
            // block absorb, present_reg holds the pending last flag
            ST_AB_K1A:
            begin
                msel = MS_C1;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    t_next = rotl64(mul_p, 31);
                    state_next = ST_AB_K1B;
                end
            end
            ST_AB_K1B:
            begin
                msel = MS_C2;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    x = rotl64(h1_reg ^ mul_p, 27) + h2_reg;
                    t_next = x;
                    state_next = ST_AB_H1;
                end
            end
            ST_AB_H1:
            begin
                msel = MS_FIVE;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    h1_next = mul_p + 64'h52dce729;
                    t_next = blk_reg[127:64];
                    state_next = ST_AB_K2A;
                end
            end
            ST_AB_K2A:
            begin
                msel = MS_C2;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    t_next = rotl64(mul_p, 33);
                    state_next = ST_AB_K2B;
                end
            end
            ST_AB_K2B:
            begin
                msel = MS_C1;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    t_next = rotl64(h2_reg ^ mul_p, 31) + h1_reg;
                    state_next = ST_AB_H2;
                end
            end
            ST_AB_H2:
            begin
                msel = MS_FIVE;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    h2_next = mul_p + 64'h38495ab5;
                    blk_next = '0;
                    if (present_reg)
                    begin
                        t_next = '0;
                        state_next = ST_FN_T2A;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            // tail of the key
            ST_FN_T2A:
            begin
                msel = MS_C2;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    t_next = rotl64(mul_p, 33);
                    state_next = ST_FN_T2B;
                end
            end
            ST_FN_T2B:
            begin
                msel = MS_C1;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    if (rem4 > 4'd8)
                    begin
                        h2_next = h2_reg ^ mul_p;
                    end
                    t_next = load_bytes(blk_reg[63:0], (rem4 > 4'd8) ? 4'd8 : rem4);
                    state_next = ST_FN_T1A;
                end
            end
            ST_FN_T1A:
            begin
                msel = MS_C1;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    t_next = rotl64(mul_p, 31);
                    state_next = ST_FN_T1B;
                end
            end
            ST_FN_T1B:
            begin
                msel = MS_C2;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    if (rem4 > 4'd0)
                    begin
                        h1_next = h1_reg ^ mul_p;
                    end
                    state_next = ST_FN_MIX;
                end
            end
            ST_FN_MIX:
            begin
                x = (h1_reg ^ {32'd0, len_reg}) + (h2_reg ^ {32'd0, len_reg});
                h1_next = x;
                h2_next = (h2_reg ^ {32'd0, len_reg}) + x;
                t_next = x ^ (x >> 33);
                state_next = ST_FM_H1A;
            end
            ST_FM_H1A:
            begin
                msel = MS_FM1;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    t_next = mul_p ^ (mul_p >> 33);
                    state_next = ST_FM_H1B;
                end
            end
            ST_FM_H1B:
            begin
                msel = MS_FM2;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    h1_next = mul_p ^ (mul_p >> 33);
                    t_next = h2_reg ^ (h2_reg >> 33);
                    state_next = ST_FM_H2A;
                end
            end
            ST_FM_H2A:
            begin
                msel = MS_FM1;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    t_next = mul_p ^ (mul_p >> 33);
                    state_next = ST_FM_H2B;
                end
            end
            ST_FM_H2B:
            begin
                msel = MS_FM2;
                mul_use = 1'b1;
                if (mul_done)
                begin
                    h2_next = mul_p ^ (mul_p >> 33);
                    state_next = ST_FN_END;
                end
            end
            ST_FN_END:
            begin
                // a = h1+h2, b = h1+2*h2 ; t holds b, pos holds a
                pos_next = h1_reg + h2_reg;
                t_next = h1_reg + h2_reg + h2_reg;
                probe_next = '0;
                present_next = 1'b1;
                h1_next = '0;
                h2_next = '0;
                blk_next = '0;
                len_next = '0;
                div_q_next = h1_reg + h2_reg;
                div_r_next = '0;
                div_cnt_next = '0;
                state_next = (probes_lim == '0) ? ST_RESULT : ST_PR_MOD;
            end
            // restoring divider, one bit a cycle
            ST_PR_MOD:
            begin
                if (!div_trial[CNT_W])
                begin
                    div_r_next = div_trial[CNT_W-1:0];
                end
                else
                begin
                    div_r_next = {div_r_reg[CNT_W-2:0], div_q_reg[63]};
                end
                div_q_next = {div_q_reg[62:0], 1'b0};
                div_cnt_next = div_cnt_reg + 7'd1;
                if (div_cnt_reg == 7'd63)
                begin
                    state_next = ST_PR_MEM;
                end
            end
            ST_PR_MEM:
            begin
                mem_addr = div_r_reg[IDX_W-1:0];
                state_next = ST_PR_CHK;
            end
            ST_PR_CHK:
            begin
                mem_addr = div_r_reg[IDX_W-1:0];
                if (qry_reg == REQ_INSERT)
                begin
                    mem_we = 1'b1;
                end
                x = pos_reg + t_reg;
                pos_next = x;
                div_q_next = x;
                div_r_next = '0;
                div_cnt_next = '0;
                probe_next = probe_reg + 1'b1;
                if (qry_reg == REQ_QUERY && !mem_rd_reg)
                begin
                    present_next = 1'b0;
                    state_next = ST_RESULT;
                end
                else if (probe_reg + 1'b1 == probes_lim)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_PR_MOD;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {present_reg, qry_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // multiplier pass counter
        if (mul_use)
        begin
            mstep_next = mul_done ? 2'd0 : mstep_reg + 2'd1;
        end
    end

    `BFIQ_ASSERT_IMP(a_no_accept_busy, state_reg != ST_IDLE, !s_axis_tready, "accepted while busy")
    `BFIQ_ASSERT_IMP(a_result_from_seq, $rose(m_axis_tvalid), $past(state_reg) == ST_RESULT, "result without sequencer")
    `BFIQ_ASSERT_IMP(a_insert_present, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[1], "insert must report present")

endmodule
